### rtl/tehs_pkg.sv
// Package for the two-ended homing sequencer.
// Holds the phase enum, register indexes, result codes, drive levels, reset values and widths.
// No dependencies.
package tehs_pkg;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_DRIVE_CW  = 3'd1,
    PH_SETTLE_A  = 3'd2,
    PH_DRIVE_CCW = 3'd3,
    PH_SETTLE_B  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    REG_DRIVE_TICKS    = 2'd0,
    REG_SETTLE_TICKS   = 2'd1,
    REG_PRESSURE_LIMIT = 2'd2,
    REG_MIN_STROKE     = 2'd3
  } cfg_idx_t;

  localparam logic [1:0] RES_OK    = 2'd0;
  localparam logic [1:0] RES_TRIP  = 2'd1;
  localparam logic [1:0] RES_STILL = 2'd2;

  localparam logic [1:0] LEVEL_NEUTRAL = 2'd0;
  localparam logic [1:0] LEVEL_CW      = 2'd1;
  localparam logic [1:0] LEVEL_CCW     = 2'd2;

  localparam logic [15:0] DRIVE_TICKS_RST    = 16'd2000;
  localparam logic [15:0] SETTLE_TICKS_RST   = 16'd100;
  localparam logic [11:0] PRESSURE_LIMIT_RST = 12'd100;
  localparam logic [15:0] MIN_STROKE_RST     = 16'd30;

  localparam int SAMPLE_W     = 12;
  localparam int TARGET_W     = 32;
  localparam int IN_TDATA_W   = 48;
  localparam int OUT_TDATA_W  = 56;
  localparam int PADDR_W      = 4;

endpackage

### rtl/two_ended_homing_sequencer.sv
// Two-ended homing sequencer: drives one axis to both ends, latches the
// encoder at each end and reports the midpoint. Uses tehs_pkg.
// Each item passes through the input register, then the result register,
// before the result transfer. Throughput: one item per cycle, stalled only by
// m_axis_tready. Reset (rst, synchronous) empties both stages, returns the
// registers to their defaults and the sequencer to idle with the relay off.
module two_ended_homing_sequencer #(
  parameter int POSITION_BITS = 32,
  parameter int SAMPLE_BITS   = 12
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [11:0] pressure_sample, [43:12] encoder_position, [47:44] zero
  input  logic [tehs_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
  // [0] command
  input  logic                                   s_axis_tuser,
  // result stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // [1:0] drive_level, [2] relay_enable, [3] busy_res, [4] success,
  // [6:5] result_code, [18:7] trip_value, [50:19] target_position, [55:51] zero
  output logic [tehs_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // done_res
  output logic                                   m_axis_tlast,
  // configuration
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [tehs_pkg::PADDR_W-1:0]           paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  localparam int P           = POSITION_BITS;
  localparam int SAMPLE_USED = (SAMPLE_BITS < tehs_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                                   : tehs_pkg::SAMPLE_W;

  // configuration registers
  logic [15:0] drive_ticks;
  logic [15:0] settle_ticks;
  logic [11:0] pressure_limit;
  logic [15:0] min_stroke;
  logic        cfg_write;
  tehs_pkg::cfg_idx_t cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_idx   = tehs_pkg::cfg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_ticks    <= tehs_pkg::DRIVE_TICKS_RST;
      settle_ticks   <= tehs_pkg::SETTLE_TICKS_RST;
      pressure_limit <= tehs_pkg::PRESSURE_LIMIT_RST;
      min_stroke     <= tehs_pkg::MIN_STROKE_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        tehs_pkg::REG_DRIVE_TICKS:    drive_ticks    <= pwdata[15:0];
        tehs_pkg::REG_SETTLE_TICKS:   settle_ticks   <= pwdata[15:0];
        tehs_pkg::REG_PRESSURE_LIMIT: pressure_limit <= pwdata[11:0];
        tehs_pkg::REG_MIN_STROKE:     min_stroke     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      tehs_pkg::REG_DRIVE_TICKS:    prdata = 32'(drive_ticks);
      tehs_pkg::REG_SETTLE_TICKS:   prdata = 32'(settle_ticks);
      tehs_pkg::REG_PRESSURE_LIMIT: prdata = 32'(pressure_limit);
      tehs_pkg::REG_MIN_STROKE:     prdata = 32'(min_stroke);
      default:                      prdata = 32'd0;
    endcase
  end

  // input register
  logic         s1_valid;
  logic         s1_cmd;
  logic [11:0]  s1_sample;
  logic [P-1:0] s1_pos;
  logic         advance;
  logic         fire;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign fire          = s1_valid && advance;
  assign s_axis_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_cmd    <= s_axis_tuser;
      s1_sample <= 12'(s_axis_tdata[SAMPLE_USED-1:0]);
      s1_pos    <= s_axis_tdata[tehs_pkg::SAMPLE_W +: P];
    end
  end

  // sequencer state
  tehs_pkg::phase_t phase, phase_next;
  logic [15:0]  tick_count, tick_count_next;
  logic [P-1:0] first_position, first_position_next;
  logic [P-1:0] second_position, second_position_next;
  logic [1:0]   last_result, last_result_next;
  logic [11:0]  last_trip, last_trip_next;
  logic [31:0]  target_reg, target_reg_next;
  logic         success_flag, success_flag_next;
  logic         relay_reg, relay_reg_next;
  logic         done_next;

  // end-of-run evaluation; with no settle the second end comes straight
  // from the item being processed
  logic [P-1:0] eval_b;
  logic [P:0]   a_x, b_x, diff_ab, diff_ba, stroke, pos_sum, sum_adj;
  logic         still;
  logic [P-1:0] mid;
  logic [15:0]  tick_inc;

  assign eval_b   = (phase == tehs_pkg::PH_DRIVE_CCW) ? s1_pos : second_position;
  assign a_x      = (P+1)'($signed(first_position));
  assign b_x      = (P+1)'($signed(eval_b));
  assign diff_ab  = b_x - a_x;
  assign diff_ba  = a_x - b_x;
  assign stroke   = diff_ab[P] ? diff_ba : diff_ab;
  assign still    = stroke < (P+1)'(min_stroke);
  assign pos_sum  = a_x + b_x;
  // round toward zero: add one to a negative sum before the halving
  assign sum_adj  = pos_sum + (P+1)'(pos_sum[P]);
  assign mid      = sum_adj[P:1];
  assign tick_inc = tick_count + 16'd1;

  always_comb begin
    phase_next           = phase;
    tick_count_next      = tick_count;
    first_position_next  = first_position;
    second_position_next = second_position;
    last_result_next     = last_result;
    last_trip_next       = last_trip;
    target_reg_next      = target_reg;
    success_flag_next    = success_flag;
    relay_reg_next       = relay_reg;
    done_next            = 1'b0;

    if (s1_cmd) begin
      if (phase == tehs_pkg::PH_IDLE) begin
        success_flag_next = 1'b1;
        last_result_next  = tehs_pkg::RES_OK;
        last_trip_next    = 12'd0;
        relay_reg_next    = 1'b1;
        tick_count_next   = 16'd0;
        phase_next        = tehs_pkg::PH_DRIVE_CW;
      end
    end else begin
      unique case (phase)
        tehs_pkg::PH_DRIVE_CW, tehs_pkg::PH_DRIVE_CCW: begin
          if (s1_sample > pressure_limit) begin
            phase_next        = tehs_pkg::PH_IDLE;
            success_flag_next = 1'b0;
            last_result_next  = tehs_pkg::RES_TRIP;
            last_trip_next    = s1_sample;
            done_next         = 1'b1;
          end else if (tick_inc == drive_ticks) begin
            tick_count_next = 16'd0;
            if (phase == tehs_pkg::PH_DRIVE_CW) begin
              first_position_next = s1_pos;
              phase_next = (settle_ticks == 16'd0) ? tehs_pkg::PH_DRIVE_CCW
                                                   : tehs_pkg::PH_SETTLE_A;
            end else begin
              second_position_next = s1_pos;
              if (settle_ticks == 16'd0) begin
                phase_next = tehs_pkg::PH_IDLE;
                done_next  = 1'b1;
                if (still) begin
                  success_flag_next = 1'b0;
                  last_result_next  = tehs_pkg::RES_STILL;
                end else begin
                  target_reg_next   = 32'($signed(mid));
                  success_flag_next = 1'b1;
                  last_result_next  = tehs_pkg::RES_OK;
                end
              end else begin
                phase_next = tehs_pkg::PH_SETTLE_B;
              end
            end
          end else begin
            tick_count_next = tick_inc;
          end
        end
        tehs_pkg::PH_SETTLE_A, tehs_pkg::PH_SETTLE_B: begin
          if (tick_inc >= settle_ticks) begin
            tick_count_next = 16'd0;
            if (phase == tehs_pkg::PH_SETTLE_A) begin
              phase_next = tehs_pkg::PH_DRIVE_CCW;
            end else begin
              phase_next = tehs_pkg::PH_IDLE;
              done_next  = 1'b1;
              if (still) begin
                success_flag_next = 1'b0;
                last_result_next  = tehs_pkg::RES_STILL;
              end else begin
                target_reg_next   = 32'($signed(mid));
                success_flag_next = 1'b1;
                last_result_next  = tehs_pkg::RES_OK;
              end
            end
          end else begin
            tick_count_next = tick_inc;
          end
        end
        tehs_pkg::PH_IDLE: ;
        default: begin
          phase_next      = tehs_pkg::PH_IDLE;
          tick_count_next = 16'd0;
        end
      endcase
    end
  end

  // result fields, taken from the state after this item
  logic [1:0]                        level_next;
  logic [tehs_pkg::OUT_TDATA_W-1:0]  result_next;

  always_comb begin
    unique case (phase_next)
      tehs_pkg::PH_DRIVE_CW:  level_next = tehs_pkg::LEVEL_CW;
      tehs_pkg::PH_DRIVE_CCW: level_next = tehs_pkg::LEVEL_CCW;
      default:                level_next = tehs_pkg::LEVEL_NEUTRAL;
    endcase
    result_next = {5'd0, target_reg_next, last_trip_next, last_result_next,
                   success_flag_next, (phase_next != tehs_pkg::PH_IDLE),
                   relay_reg_next, level_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= tehs_pkg::PH_IDLE;
      tick_count      <= 16'd0;
      first_position  <= '0;
      second_position <= '0;
      last_result     <= tehs_pkg::RES_OK;
      last_trip       <= 12'd0;
      target_reg      <= 32'd0;
      success_flag    <= 1'b1;
      relay_reg       <= 1'b0;
    end else if (fire) begin
      phase           <= phase_next;
      tick_count      <= tick_count_next;
      first_position  <= first_position_next;
      second_position <= second_position_next;
      last_result     <= last_result_next;
      last_trip       <= last_trip_next;
      target_reg      <= target_reg_next;
      success_flag    <= success_flag_next;
      relay_reg       <= relay_reg_next;
    end
  end

  // result register: load on each processed item, drop after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_axis_tdata <= result_next;
      m_axis_tlast <= done_next;
    end
  end

endmodule
